// ----- design/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg: shared constants and types for the 3x3 median filter.
// Holds sizes, register indexes and the output result record.
// ----------------------------------------------------------------------------
`default_nettype none
package mf3_pkg;
    localparam int unsigned MAX_COLS   = 1024;
    localparam int unsigned PIXEL_BITS = 16;
    localparam int unsigned ROW_W      = 16;
    localparam int unsigned COL_W      = 10;
    localparam int unsigned CFG_COLS_W = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } t_cfg_reg;

    // One output result as delivered to the user.
    typedef struct packed {
        logic [ROW_W-1:0]      out_row;
        logic [COL_W-1:0]      out_col;
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  is_median;
        logic                  last;
    } t_result;
endpackage
`default_nettype wire

// ----- design/mf3_if.sv -----
// ----------------------------------------------------------------------------
// mf3_if: valid/ready channel interfaces for pixels, results and config.
// Each carries valid, ready and a payload with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface mf3_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic [15:0] pixel_out;
    logic        is_median;
    logic        last;
    modport source (output valid, output out_row, output out_col, output pixel_out,
                    output is_median, output last, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input pixel_out, input is_median, input last, output ready);
endinterface

interface mf3_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter with position tagging.
// Front: counters and line buffers; back: window, median and emission.
// ----------------------------------------------------------------------------
// One pixel transfer is accepted per clock while results drain freely. A
// pixel causes zero to three results, sent one per clock while the result
// port is ready; in frames of 3x3 or more, a pixel that closes a row below
// the first causes two, one on the last row after its first column two, and
// the frame's last pixel three; the input stalls meanwhile. Results pass the
// intake, queue, job and result registers. Configuration writes restart the
// frame and belong where nothing is in flight. Line buffers are simple
// dual-port RAMs of MAX_COLS entries with no clearing pass.
`default_nettype none
module median_filter_3x3 #(
    parameter int unsigned MAX_COLS   = mf3_pkg::MAX_COLS,
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS
) (
    input wire        i_clk,
    input wire        i_rst_n,
    mf3_pix_if.sink   pix,
    mf3_cfg_if.sink   cfg,
    mf3_res_if.source res
);
    logic q_valid, q_ready, q_small, q_border;
    logic [3*PIXEL_BITS-1:0] q_col;
    logic [PIXEL_BITS-1:0] q_mid, q_p;
    logic [15:0] q_row;
    logic [9:0] q_colpos;
    logic [2:0] q_flags;

    assign cfg.ready = 1'b1;

    mf3_front #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_in_valid(pix.valid), .o_in_ready(pix.ready), .i_pixel(pix.pixel_in),
        .i_cfg_we(cfg.valid), .i_cfg_idx(cfg.index), .i_cfg_data(cfg.data),
        .i_q_ready(q_ready), .o_q_valid(q_valid), .o_q_col(q_col), .o_q_mid(q_mid),
        .o_q_p(q_p), .o_q_row(q_row), .o_q_colpos(q_colpos), .o_q_flags(q_flags),
        .o_q_small(q_small), .o_q_border(q_border));

    mf3_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_col(q_col), .i_q_mid(q_mid),
        .i_q_p(q_p), .i_q_row(q_row), .i_q_colpos(q_colpos), .i_q_flags(q_flags),
        .i_q_small(q_small), .i_q_border(q_border), .res(res));
endmodule
`default_nettype wire

// ----- design/mf3_ram.sv -----
// ----------------------------------------------------------------------------
// mf3_ram: generic simple dual-port RAM with a registered read.
// One write port and one read port; a read of the address being written
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none
module mf3_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/mf3_front.sv -----
// ----------------------------------------------------------------------------
// mf3_front: pixel intake, position counters and line buffers.
// Builds each 3x3 window column and classifies the results an input causes.
// Buffers are read at the new column and written once the intake register
// advances; a write still pending to the column being read is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none
module mf3_front #(
    parameter int unsigned MAX_COLS   = mf3_pkg::MAX_COLS,
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [15:0]            i_pixel,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire [15:0]            i_cfg_data,
    input  wire                   i_q_ready,
    output logic                  o_q_valid,
    output logic [3*PIXEL_BITS-1:0] o_q_col,
    output logic [PIXEL_BITS-1:0] o_q_mid,
    output logic [PIXEL_BITS-1:0] o_q_p,
    output logic [15:0]           o_q_row,
    output logic [9:0]            o_q_colpos,
    output logic [2:0]            o_q_flags,
    output logic                  o_q_small,
    output logic                  o_q_border
);
    localparam int unsigned AW = $clog2(MAX_COLS);
    localparam int unsigned CW = AW + 1;

    logic [10:0] r_cols_reg;
    logic [15:0] r_rows_reg;
    logic [CW-1:0] r_col;
    logic [15:0] r_row;
    logic [CW-1:0] cols_eff;
    logic [15:0] rows_eff;

    logic r_s1_v;
    logic [PIXEL_BITS-1:0] r_s1_p;
    logic [CW-1:0] r_s1_c;
    logic [15:0] r_s1_r;
    logic r_s1_last_col, r_s1_last_row, r_s1_small;
    logic r_byp_v;
    logic [PIXEL_BITS-1:0] r_byp_up, r_byp_mid;
    logic [PIXEL_BITS-1:0] up_rd, mid_rd, up_val, mid_val;
    logic accept, adv, buf_we, byp_hit;

    always_comb begin
        cols_eff = (r_cols_reg == 11'd0) ? CW'(1) :
                   ({21'd0, r_cols_reg} > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(r_cols_reg);
        rows_eff = (r_rows_reg == 16'd0) ? 16'd1 : r_rows_reg;
    end

    assign adv        = !o_q_valid || i_q_ready;
    assign o_in_ready = adv && !i_cfg_we;
    assign accept     = i_in_valid && o_in_ready;
    assign buf_we     = r_s1_v && adv;
    assign byp_hit    = accept && buf_we && (r_s1_c == r_col);
    assign up_val     = r_byp_v ? r_byp_up : up_rd;
    assign mid_val    = r_byp_v ? r_byp_mid : mid_rd;

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_upper (
        .i_clk, .i_we(buf_we), .i_waddr(r_s1_c[AW-1:0]), .i_wdata(mid_val),
        .i_re(accept), .i_raddr(r_col[AW-1:0]), .o_rdata(up_rd));

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_middle (
        .i_clk, .i_we(buf_we), .i_waddr(r_s1_c[AW-1:0]), .i_wdata(r_s1_p),
        .i_re(accept), .i_raddr(r_col[AW-1:0]), .o_rdata(mid_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_reg <= 11'd512;
            r_rows_reg <= 16'd512;
            r_col <= '0;
            r_row <= '0;
            r_s1_v <= 1'b0;
            r_byp_v <= 1'b0;
            o_q_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mf3_pkg::REG_FRAME_COLS) begin
                    r_cols_reg <= i_cfg_data[10:0];
                end else begin
                    r_rows_reg <= i_cfg_data;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (r_col + CW'(1) >= cols_eff) begin
                    r_col <= '0;
                    r_row <= (r_row + 16'd1 >= rows_eff) ? 16'd0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (adv) begin
                r_s1_v <= accept;
                r_byp_v <= byp_hit;
                o_q_valid <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_p <= PIXEL_BITS'(i_pixel);
            r_s1_c <= r_col;
            r_s1_r <= r_row;
            r_s1_last_col <= (r_col == cols_eff - CW'(1));
            r_s1_last_row <= (r_row == rows_eff - 16'd1);
            r_s1_small <= (rows_eff < 16'd3) || (cols_eff < CW'(3));
            r_byp_up <= mid_val;
            r_byp_mid <= r_s1_p;
        end
        if (adv) begin
            o_q_col <= {up_val, mid_val, r_s1_p};
            o_q_mid <= mid_val;
            o_q_p <= r_s1_p;
            o_q_row <= r_s1_r;
            o_q_colpos <= 10'(r_s1_c);
            o_q_flags <= {(r_s1_r != 16'd0) && (r_s1_c != '0),
                          (r_s1_r != 16'd0) && r_s1_last_col, r_s1_last_row};
            o_q_small <= r_s1_small;
            o_q_border <= (r_s1_r < 16'd2) || (r_s1_c < CW'(2));
        end
    end
endmodule
`default_nettype wire

// ----- design/mf3_back.sv -----
// ----------------------------------------------------------------------------
// mf3_back: window registers, median network and result sequencing.
// Takes classified items and emits zero to three results each.
// ----------------------------------------------------------------------------
`default_nettype none
module mf3_back #(
    parameter int unsigned PIXEL_BITS = mf3_pkg::PIXEL_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_q_valid,
    output logic                    o_q_ready,
    input  wire [3*PIXEL_BITS-1:0]  i_q_col,
    input  wire [PIXEL_BITS-1:0]    i_q_mid,
    input  wire [PIXEL_BITS-1:0]    i_q_p,
    input  wire [15:0]              i_q_row,
    input  wire [9:0]               i_q_colpos,
    input  wire [2:0]               i_q_flags,
    input  wire                     i_q_small,
    input  wire                     i_q_border,
    mf3_res_if.source               res
);
    typedef logic [PIXEL_BITS-1:0] t_pix;

    t_pix r_w [9];
    t_pix w_n [9];
    t_pix row_srt [9];
    t_pix r_srt [9];
    t_pix med;

    // Pending job.
    logic r_jv;
    logic [2:0] r_pend;
    t_pix r_mid, r_p, r_center;
    logic [15:0] r_row;
    logic [9:0] r_colpos;
    logic r_border;

    function automatic void cswap(inout t_pix a, inout t_pix b);
        t_pix t;
        if (a > b) begin
            t = a; a = b; b = t;
        end
    endfunction

    // Each window row is sorted before it is registered.
    always_comb begin
        t_pix v [9];
        for (int i = 0; i < 9; i++) v[i] = w_n[i];
        for (int k = 0; k < 3; k++) begin
            cswap(v[3*k+1], v[3*k+2]);
            cswap(v[3*k],   v[3*k+1]);
            cswap(v[3*k+1], v[3*k+2]);
        end
        for (int i = 0; i < 9; i++) row_srt[i] = v[i];
    end

    // Max of mins, median of mids, min of maxes, then their median.
    always_comb begin
        t_pix v [9];
        for (int i = 0; i < 9; i++) v[i] = r_srt[i];
        cswap(v[0], v[3]); cswap(v[3], v[6]);
        cswap(v[4], v[7]); cswap(v[1], v[4]); cswap(v[4], v[7]);
        cswap(v[2], v[5]); cswap(v[5], v[8]); cswap(v[2], v[5]);
        cswap(v[4], v[2]); cswap(v[6], v[4]); cswap(v[4], v[2]);
        med = v[4];
    end

    always_comb begin
        w_n[0] = r_w[1]; w_n[1] = r_w[2]; w_n[2] = i_q_col[3*PIXEL_BITS-1 -: PIXEL_BITS];
        w_n[3] = r_w[4]; w_n[4] = r_w[5]; w_n[5] = i_q_col[2*PIXEL_BITS-1 -: PIXEL_BITS];
        w_n[6] = r_w[7]; w_n[7] = r_w[8]; w_n[8] = i_q_col[PIXEL_BITS-1:0];
    end

    logic [2:0] pend_n;
    logic take, out_ok, pop;
    assign out_ok = !res.valid || res.ready;
    assign pop = r_jv && out_ok && (r_pend == 3'b001 || r_pend == 3'b010 ||
                 r_pend == 3'b100 || r_pend == 3'b000);
    assign o_q_ready = !r_jv || pop;
    assign take = i_q_valid && o_q_ready;
    assign pend_n = i_q_small ? 3'b001 : i_q_flags;

    logic [2:0] rem;
    logic sel_a, sel_b;
    assign sel_a = r_pend[2];
    assign sel_b = !r_pend[2] && r_pend[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= 1'b0;
            r_pend <= 3'b000;
            res.valid <= 1'b0;
            for (int i = 0; i < 9; i++) r_w[i] <= '0;
        end else begin
            if (out_ok) res.valid <= r_jv && (r_pend != 3'b000);
            if (r_jv && out_ok) begin
                r_pend <= rem;
                if (pop) r_jv <= 1'b0;
            end
            if (take) begin
                r_jv <= 1'b1;
                r_pend <= pend_n;
                for (int i = 0; i < 9; i++) r_w[i] <= w_n[i];
            end
        end
    end

    always_comb begin
        rem = r_pend;
        if (sel_a) rem[2] = 1'b0;
        else if (sel_b) rem[1] = 1'b0;
        else rem[0] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int i = 0; i < 9; i++) r_srt[i] <= row_srt[i];
            r_mid <= i_q_mid;
            r_p <= i_q_p;
            r_center <= r_w[5];
            r_row <= i_q_row;
            r_colpos <= i_q_colpos;
            r_border <= i_q_border;
        end
        if (r_jv && out_ok) begin
            res.last <= (rem == 3'b000);
            if (r_pend == 3'b000) begin
                res.is_median <= 1'b0;
            end else if (sel_a) begin
                res.out_row <= r_row - 16'd1;
                res.out_col <= r_colpos - 10'd1;
                res.pixel_out <= 16'(r_border ? r_center : med);
                res.is_median <= !r_border;
            end else if (sel_b) begin
                res.out_row <= r_row - 16'd1;
                res.out_col <= r_colpos;
                res.pixel_out <= 16'(r_mid);
                res.is_median <= 1'b0;
            end else begin
                res.out_row <= r_row;
                res.out_col <= r_colpos;
                res.pixel_out <= 16'(r_p);
                res.is_median <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// tb_median_filter_3x3: self-checking testbench for the 3x3 median filter.
// A class tracks the frame position, the line buffers and the window, works
// out the positioned results of every accepted pixel and checks each result
// transfer against the oldest one. Directed frames come first, then random
// frame sizes and pixel data; random gaps and output stalls stop near the end.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_median_filter_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int ITEM_TOTAL     = 330;

    class median_tracker;
        bit [10:0]  cols_reg;
        bit [15:0]  rows_reg;
        bit [15:0]  upper_line[mf3_pkg::MAX_COLS];
        bit [15:0]  middle_line[mf3_pkg::MAX_COLS];
        bit [15:0]  win[3][3];
        int unsigned row_pos;
        int unsigned col_pos;
        mf3_pkg::t_result pending_q[$];
        int         errors;

        function void reset_state();
            cols_reg = 11'd512;
            rows_reg = 16'd512;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            row_pos = 0;
            col_pos = 0;
            pending_q.delete();
            errors = 0;
        endfunction

        function void write_reg(mf3_pkg::t_cfg_reg idx, bit [15:0] value);
            if (idx == mf3_pkg::REG_FRAME_COLS) cols_reg = value[10:0];
            else rows_reg = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function bit [15:0] window_median();
            int vals[9];
            for (int i = 0; i < 9; i++) vals[i] = win[i / 3][i % 3];
            vals.sort();
            return 16'(vals[4]);
        endfunction

        function void push_result(int unsigned r, int unsigned c, bit [15:0] v, bit med);
            mf3_pkg::t_result t;
            t.out_row   = r[15:0];
            t.out_col   = c[9:0];
            t.pixel_out = v;
            t.is_median = med;
            t.last      = 1'b0;
            pending_q.insert(pending_q.size(), t);
        endfunction

        function void note_pixel(bit [15:0] p);
            int unsigned cols, rows, r, c;
            bit [15:0] up, mid;
            int before_n;
            cols = (cols_reg == 0) ? 1 : cols_reg;
            rows = (rows_reg == 0) ? 1 : rows_reg;
            if (cols > mf3_pkg::MAX_COLS) cols = mf3_pkg::MAX_COLS;
            r = row_pos;
            c = col_pos;
            up  = upper_line[c];
            mid = middle_line[c];
            before_n = pending_q.size();
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = p;
            if (rows < 3 || cols < 3) begin
                push_result(r, c, p, 1'b0);
            end else begin
                if (r >= 1 && c >= 1) begin
                    if (r >= 2 && c >= 2) push_result(r - 1, c - 1, window_median(), 1'b1);
                    else push_result(r - 1, c - 1, win[1][1], 1'b0);
                end
                if (r >= 1 && c == cols - 1) push_result(r - 1, c, mid, 1'b0);
                if (r == rows - 1) push_result(r, c, p, 1'b0);
            end
            if (pending_q.size() > before_n) pending_q[pending_q.size() - 1].last = 1'b1;
            upper_line[c]  = mid;
            middle_line[c] = p;
            if (c + 1 >= cols) begin
                col_pos = 0;
                row_pos = (r + 1 >= rows) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(mf3_pkg::t_result got);
            mf3_pkg::t_result exp_r;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d pixel %0h", $time,
                         got.out_row, got.out_col, got.pixel_out);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.out_row !== exp_r.out_row) begin
                $display("%0t: out_row expected %0d actual %0d", $time, exp_r.out_row,
                         got.out_row);
                errors++;
            end
            if (got.out_col !== exp_r.out_col) begin
                $display("%0t: out_col expected %0d actual %0d", $time, exp_r.out_col,
                         got.out_col);
                errors++;
            end
            if (got.pixel_out !== exp_r.pixel_out) begin
                $display("%0t: pixel_out expected %0h actual %0h", $time, exp_r.pixel_out,
                         got.pixel_out);
                errors++;
            end
            if (got.is_median !== exp_r.is_median) begin
                $display("%0t: is_median expected %0b actual %0b", $time, exp_r.is_median,
                         got.is_median);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last expected %0b actual %0b", $time, exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mf3_pix_if pix ();
    mf3_cfg_if cfg ();
    mf3_res_if res ();

    median_filter_3x3 dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .pix    (pix),
        .cfg    (cfg),
        .res    (res)
    );

    median_tracker tracker = new();
    bit  idle_on = 1'b1;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  sent = 0;

    always #1 i_clk = ~i_clk;

    // Output back-pressure in random bursts.
    always @(posedge i_clk) begin
        if (idle_on && stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 15);
            res.ready  <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            mf3_pkg::t_result got;
            bit any_transfer;
            any_transfer = 1'b0;
            if (res.valid && res.ready) begin
                got.out_row   = res.out_row;
                got.out_col   = res.out_col;
                got.pixel_out = res.pixel_out;
                got.is_median = res.is_median;
                got.last      = res.last;
                tracker.check_result(got);
                any_transfer = 1'b1;
            end
            if (pix.valid && pix.ready) begin
                tracker.note_pixel(pix.pixel_in);
                any_transfer = 1'b1;
            end
            if (cfg.valid && cfg.ready) begin
                tracker.write_reg(mf3_pkg::t_cfg_reg'(cfg.index), cfg.data);
                any_transfer = 1'b1;
            end
            quiet_cycles = any_transfer ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_median_filter_3x3: done, errors");
                $finish;
            end
        end
    end

    task automatic write_cfg(mf3_pkg::t_cfg_reg idx, bit [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(bit [15:0] value);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.pixel_in <= value;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic set_frame(bit [15:0] cols, bit [15:0] rows);
        wait_drained();
        write_cfg(mf3_pkg::REG_FRAME_COLS, cols);
        write_cfg(mf3_pkg::REG_FRAME_ROWS, rows);
    endtask

    function automatic bit [15:0] random_pixel(bit narrow);
        return narrow ? 16'($urandom_range(0, 7)) : 16'($urandom);
    endfunction

    task automatic run_random(int count, bit narrow);
        for (int i = 0; i < count; i++) send_pixel(random_pixel(narrow));
    endtask

    initial begin
        bit [15:0] directed[18];
        int cols, rows, count;
        directed = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                     16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000,
                     16'h0007, 16'h0007, 16'h0007, 16'h0003, 16'h0003,
                     16'h0009, 16'h0009, 16'h0009, 16'h0009};
        i_rst_n      <= 1'b0;
        pix.valid    <= 1'b0;
        pix.pixel_in <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= mf3_pkg::REG_FRAME_COLS;
        cfg.data     <= '0;
        tracker.reset_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two back-to-back 3x3 frames: extremes, then ties; counters wrap.
        set_frame(16'd3, 16'd3);
        foreach (directed[i]) send_pixel(directed[i]);
        // Zero sizes act as one, and 2x2 frames pass through.
        set_frame(16'd0, 16'd0);
        send_pixel(16'h1234);
        send_pixel(16'hFEDC);
        set_frame(16'd2, 16'd2);
        run_random(5, 1'b0);

        // Oversized width on a one-row frame, then a partial tall frame.
        set_frame(16'd2047, 16'd1);
        run_random(20, 1'b0);
        set_frame(16'd2047, 16'd65535);
        run_random(12, 1'b1);

        while (sent < ITEM_TOTAL) begin
            if (sent >= 250) idle_on = 1'b0;
            cols = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            rows = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            if ($urandom_range(0, 9) == 0) rows = 65535;
            set_frame(cols[15:0], rows[15:0]);
            if (cols == 0) cols = 1;
            if (rows == 0) rows = 1;
            count = (rows > 8 ? 4 : rows) * cols * $urandom_range(1, 2)
                    + $urandom_range(0, cols);
            if (count > ITEM_TOTAL - sent) count = ITEM_TOTAL - sent;
            if (sent < 120) begin
                run_random(count / 2, 1'b0);
                wait_drained();
                run_random(count - count / 2, 1'b0);
            end else begin
                run_random(count, 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        if (tracker.errors == 0) begin
            $display("tb_median_filter_3x3: done, clean");
        end else begin
            $display("tb_median_filter_3x3: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- median_filter_3x3.f -----
design/mf3_pkg.sv
design/mf3_if.sv
design/mf3_ram.sv
design/mf3_front.sv
design/mf3_back.sv
design/median_filter_3x3.sv
tb/tb_median_filter_3x3.sv
